@@ hw/rtl/pid_controller_sample_gated_defines.svh @@
// assertion macros for the sample-gated pid controller
`ifndef PID_CONTROLLER_SAMPLE_GATED_DEFINES_SVH
`define PID_CONTROLLER_SAMPLE_GATED_DEFINES_SVH

// same-cycle implication, checked on clk with reset masked
`define PIDSG_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define PIDSG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pidsg_pkg.sv @@
// shared types and constants for the sample-gated pid controller
package pidsg_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int CMD_DEPTH_DEF      = 4;
  localparam int OUT_DEPTH_DEF      = 4;

  localparam int DATA_W    = 16;
  localparam int TIME_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int PROD_W    = DATA_W + DIFF_W;
  localparam int CLAMP_W   = 40;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int APB_W     = 32;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_MS  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OUT_UPPER  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OUT_LOWER  = 3'd5;

  // input mode codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_UPDATE,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] target;
    logic [TIME_W-1:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     updated;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic signed [DIFF_W-1:0] err;
    logic signed [DIFF_W-1:0] drop;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic [DATA_W-1:0]        period_ms;
    logic signed [DATA_W-1:0] out_upper;
    logic signed [DATA_W-1:0] out_lower;
  } cfg_t;

endpackage

@@ hw/rtl/pidsg_fifo.sv @@
// small register queue used between front and back and on the result side
module pidsg_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [W-1:0]               wr_data,
  input  logic                       rd_en,
  output logic [W-1:0]               rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full  = (count_r == (AW+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];

endmodule

@@ hw/rtl/pidsg_front.sv @@
// front end: time gating, item classification, error and drop forming
module pidsg_front
  import pidsg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  in_item_t in_item,
  input  logic     accept,
  output cmd_t     cmd
);

  logic [TIME_W-1:0]        last_time_r, last_time_nxt;
  logic signed [DATA_W-1:0] last_meas_r, last_meas_nxt;
  logic [TIME_W-1:0]        time_base;
  logic [TIME_W-1:0]        elapsed;
  logic                     due;

  // clock going backward pulls the time base down to now
  always_comb begin
    time_base = (last_time_r > in_item.now_ms) ? in_item.now_ms : last_time_r;
    elapsed   = in_item.now_ms - time_base;
    due       = elapsed > TIME_W'(cfg.period_ms);
  end

  // classify the item and form the differences
  always_comb begin
    cmd.err  = DIFF_W'(in_item.target) - DIFF_W'(in_item.measured);
    cmd.drop = DIFF_W'(last_meas_r) - DIFF_W'(in_item.measured);
    if (in_item.mode == MODE_CLEAR) begin
      cmd.kind = CMD_CLEAR;
    end else if (due) begin
      cmd.kind = CMD_UPDATE;
    end else begin
      cmd.kind = CMD_HOLD;
    end
  end

  // time base and last measurement follow accepted items
  always_comb begin
    last_time_nxt = last_time_r;
    last_meas_nxt = last_meas_r;
    if (accept) begin
      case (cmd.kind)
        CMD_CLEAR: begin
          last_time_nxt = in_item.now_ms;
          last_meas_nxt = '0;
        end
        CMD_UPDATE: begin
          last_time_nxt = in_item.now_ms;
          last_meas_nxt = in_item.measured;
        end
        default: begin
          last_time_nxt = time_base;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      last_meas_r <= '0;
    end else begin
      last_time_r <= last_time_nxt;
      last_meas_r <= last_meas_nxt;
    end
  end

endmodule

@@ hw/rtl/pidsg_back.sv @@
// back end: gain products, integrator, output clamp and held drive
module pidsg_back
  import pidsg_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int OUT_DEPTH      = OUT_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfg_t                         cfg,
  input  cmd_t                         cmd,
  input  logic                         cmd_empty,
  input  logic [$clog2(OUT_DEPTH):0]   out_count,
  output logic                         cmd_pop,
  output logic                         out_wr,
  output out_item_t                    out_item
);

  localparam int SH_W  = PROD_W - GAIN_FRAC_BITS;
  localparam int SUM_W = SH_W + 2;
  localparam int CW    = $clog2(OUT_DEPTH) + 1;

  function automatic logic signed [DATA_W-1:0] clamp_lim(
    input logic signed [CLAMP_W-1:0] x,
    input logic signed [DATA_W-1:0]  hi,
    input logic signed [DATA_W-1:0]  lo
  );
    logic signed [DATA_W-1:0] res;
    if (x > CLAMP_W'(hi)) begin
      res = hi;
    end else if (x < CLAMP_W'(lo)) begin
      res = lo;
    end else begin
      res = DATA_W'(x);
    end
    return res;
  endfunction

  logic                     s1_v_r;
  cmd_kind_t                s1_kind_r;
  logic signed [SH_W-1:0]   p_r, i_r, d_r;
  logic signed [PROD_W-1:0] p_full, i_full, d_full;
  logic signed [DATA_W-1:0] integ_r, integ_nxt;
  logic signed [DATA_W-1:0] drive_r, drive_nxt;
  logic signed [SUM_W-1:0]  acc_sum, tot_sum;
  logic signed [DATA_W-1:0] acc_cl, tot_cl;
  logic                     upd;

  // issue only when the result queue has room for everything in flight
  assign cmd_pop = !cmd_empty &&
                   ((out_count + CW'(s1_v_r)) < CW'(OUT_DEPTH));

  // stage 1: three gain products
  always_comb begin
    p_full = PROD_W'(cfg.prop_gain) * PROD_W'(cmd.err);
    i_full = PROD_W'(cfg.integ_gain) * PROD_W'(cmd.err);
    d_full = PROD_W'(cfg.deriv_gain) * PROD_W'(cmd.drop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_kind_r <= cmd.kind;
      p_r       <= SH_W'(p_full >>> GAIN_FRAC_BITS);
      i_r       <= SH_W'(i_full >>> GAIN_FRAC_BITS);
      d_r       <= SH_W'(d_full >>> GAIN_FRAC_BITS);
    end
  end

  // stage 2: integrator, sum and clamps
  always_comb begin
    acc_sum = SUM_W'(integ_r) + SUM_W'(i_r);
    acc_cl  = clamp_lim(CLAMP_W'(acc_sum), cfg.out_upper, cfg.out_lower);
    tot_sum = SUM_W'(p_r) + SUM_W'(acc_cl) + SUM_W'(d_r);
    tot_cl  = clamp_lim(CLAMP_W'(tot_sum), cfg.out_upper, cfg.out_lower);
  end

  // controller state update per item kind
  always_comb begin
    integ_nxt = integ_r;
    drive_nxt = drive_r;
    upd       = 1'b0;
    if (s1_v_r) begin
      case (s1_kind_r)
        CMD_UPDATE: begin
          integ_nxt = acc_cl;
          drive_nxt = tot_cl;
          upd       = 1'b1;
        end
        CMD_CLEAR: begin
          integ_nxt = '0;
          drive_nxt = '0;
        end
        default: begin
          upd = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      drive_r <= '0;
    end else begin
      integ_r <= integ_nxt;
      drive_r <= drive_nxt;
    end
  end

  assign out_wr           = s1_v_r;
  assign out_item.drive   = drive_nxt;
  assign out_item.updated = upd;

endmodule

@@ hw/rtl/pid_controller_sample_gated.sv @@
// Sample-gated PID controller, top level: register port, front, queues, back.
// A result passes through the command queue, the stage 1 registers of the back end
// and the result queue. Throughput: one item per cycle while the result queue has room;
// the integrator and clamp loop in the back end closes through the single integrator register.
// Reset (rst_n low, synchronous): queues empty, controller state zero,
// registers at their reset values.
`include "pid_controller_sample_gated_defines.svh"

module pid_controller_sample_gated
  import pidsg_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int CMD_DEPTH      = CMD_DEPTH_DEF,
  parameter int OUT_DEPTH      = OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input item channel
  input  logic               push,
  output logic               full,
  input  in_item_t           in_item,
  // result channel
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_item,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready
);

  localparam int OCW = $clog2(OUT_DEPTH) + 1;
  localparam int CCW = $clog2(CMD_DEPTH) + 1;

  cfg_t                    cfg_r, cfg_nxt;
  logic                    cfg_wr;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    in_accept;
  cmd_t                    cmd_in, cmd_out;
  logic [$bits(cmd_t)-1:0] cmd_rd;
  logic                    cmd_full, cmd_empty, cmd_pop;
  logic [CCW-1:0]          cmd_count;
  logic                    out_wr;
  out_item_t               back_item;
  logic [$bits(out_item_t)-1:0] out_rd;
  logic                    out_full;
  logic [OCW-1:0]          out_count;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_PROP_GAIN:  cfg_nxt.prop_gain  = pwdata[DATA_W-1:0];
        REG_INTEG_GAIN: cfg_nxt.integ_gain = pwdata[DATA_W-1:0];
        REG_DERIV_GAIN: cfg_nxt.deriv_gain = pwdata[DATA_W-1:0];
        REG_PERIOD_MS:  cfg_nxt.period_ms  = pwdata[DATA_W-1:0];
        REG_OUT_UPPER:  cfg_nxt.out_upper  = pwdata[DATA_W-1:0];
        REG_OUT_LOWER:  cfg_nxt.out_lower  = pwdata[DATA_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain  <= 16'sd256;
      cfg_r.integ_gain <= '0;
      cfg_r.deriv_gain <= '0;
      cfg_r.period_ms  <= 16'd10;
      cfg_r.out_upper  <= 16'sh7FFF;
      cfg_r.out_lower  <= 16'sh8000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_PROP_GAIN:  prdata = {16'b0, cfg_r.prop_gain};
      REG_INTEG_GAIN: prdata = {16'b0, cfg_r.integ_gain};
      REG_DERIV_GAIN: prdata = {16'b0, cfg_r.deriv_gain};
      REG_PERIOD_MS:  prdata = {16'b0, cfg_r.period_ms};
      REG_OUT_UPPER:  prdata = {16'b0, cfg_r.out_upper};
      REG_OUT_LOWER:  prdata = {16'b0, cfg_r.out_lower};
      default:        prdata = '0;
    endcase
  end

  // front end
  assign full      = cmd_full;
  assign in_accept = push && !cmd_full;

  pidsg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_item (in_item),
    .accept  (in_accept),
    .cmd     (cmd_in)
  );

  // command queue between front and back
  pidsg_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .full    (cmd_full),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  assign cmd_out = cmd_t'(cmd_rd);

  // back end
  pidsg_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .OUT_DEPTH      (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .out_count (out_count),
    .cmd_pop   (cmd_pop),
    .out_wr    (out_wr),
    .out_item  (back_item)
  );

  // result queue
  pidsg_fifo #(
    .W     ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_wr),
    .wr_data (back_item),
    .rd_en   (pop),
    .rd_data (out_rd),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  assign out_item = out_item_t'(out_rd);

  // checks
  `PIDSG_ASSERT_SAME(a_no_result_overflow, out_wr, !out_full, "result written into a full queue")
  `PIDSG_ASSERT_NEXT(a_item_queued, in_accept, !cmd_empty, "accepted item missing from command queue")
  `PIDSG_ASSERT_SAME(a_cmd_full_count, cmd_full, cmd_count == CCW'(CMD_DEPTH), "command queue full flag disagrees with its count")
  `PIDSG_ASSERT_SAME(a_drive_in_limits, !empty && out_item.updated && (cfg_r.out_upper >= cfg_r.out_lower), (out_item.drive <= cfg_r.out_upper) && (out_item.drive >= cfg_r.out_lower), "updated drive outside limits")

endmodule
